@@ rtl/rfbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfbs_pkg
// Shared types, register map and constants of the horizontal row filter.
// ----------------------------------------------------------------------------
package rfbs_pkg;

  localparam int PIX_W             = 8;
  localparam int MODE_W            = 2;
  localparam int WIDTH_REG_W       = 7;
  localparam int MAX_ROW_WIDTH_DEF = 64;
  localparam int CELL_COUNT        = 4;   // previous pixels held in the window
  localparam int TAP_COUNT         = 5;   // current pixel plus the window
  localparam int SLOT_COUNT        = 3;   // most results one pixel can cause
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;

  // Register map (index taken from address bit 2)
  localparam logic REG_FILTER_MODE = 1'b0;
  localparam logic REG_ROW_WIDTH   = 1'b1;

  localparam logic [WIDTH_REG_W-1:0] ROW_WIDTH_RESET = 7'd20;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLUR3   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLUR5   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd3;

  // Reciprocal multipliers: floor(s/3) = (s*2731)>>13 for s <= 765,
  // floor(s/5) = (s*3277)>>14 for s <= 1275.
  localparam logic [11:0] DIV3_MUL   = 12'd2731;
  localparam int          DIV3_SHIFT = 13;
  localparam logic [11:0] DIV5_MUL   = 12'd3277;
  localparam int          DIV5_SHIFT = 14;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Link between neighboring window cells
  typedef struct packed {
    logic [PIX_W-1:0] pixel;    // raw pixel held by the cell
    logic             valid;    // cell holds a pixel of the current row
    logic [PIX_W-1:0] clamped;  // pixel with left-edge replication applied
  } tap_link_t;

  // One queued result
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/rfbs_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfbs_cell
// One window cell: holds a past pixel of the row and replicates the left edge.
// ----------------------------------------------------------------------------
module rfbs_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire logic                row_done,
  input  wire rfbs_pkg::tap_link_t up,
  output rfbs_pkg::tap_link_t      down
);

  logic [rfbs_pkg::PIX_W-1:0] pixel_r;
  logic                       valid_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_r <= up.pixel;
    end
  end

  // drop validity when the row closes so the next row starts at the edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= row_done ? 1'b0 : up.valid;
    end
  end

  always_comb begin
    down.pixel   = pixel_r;
    down.valid   = valid_r;
    down.clamped = valid_r ? pixel_r : up.clamped;
  end

endmodule
`default_nettype wire

@@ rtl/rfbs_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfbs_filter
// Five-pixel neighborhood filter: pass, 3-tap blur, 5-tap blur or sharpen.
// ----------------------------------------------------------------------------
module rfbs_filter (
  input  wire logic [rfbs_pkg::MODE_W-1:0] mode,
  input  wire logic [rfbs_pkg::PIX_W-1:0]  nb [rfbs_pkg::TAP_COUNT],
  output logic      [rfbs_pkg::PIX_W-1:0]  pixel
);

  logic [9:0]  sum3;
  logic [10:0] sum5;
  logic [21:0] prod3;
  logic [22:0] prod5;
  logic [8:0]  side_sum;
  logic [7:0]  side_avg;
  logic signed [9:0] sharp;

  always_comb begin
    sum3     = 10'(nb[1]) + 10'(nb[2]) + 10'(nb[3]);
    sum5     = 11'(sum3) + 11'(nb[0]) + 11'(nb[4]);
    prod3    = 22'(sum3) * 22'(rfbs_pkg::DIV3_MUL);
    prod5    = 23'(sum5) * 23'(rfbs_pkg::DIV5_MUL);
    side_sum = 9'(nb[1]) + 9'(nb[3]);
    side_avg = side_sum[8:1];
    sharp    = $signed({1'b0, nb[2], 1'b0}) - $signed({2'b00, side_avg});

    case (mode)
      rfbs_pkg::MODE_BLUR3: begin
        pixel = prod3[rfbs_pkg::DIV3_SHIFT +: rfbs_pkg::PIX_W];
      end
      rfbs_pkg::MODE_BLUR5: begin
        pixel = prod5[rfbs_pkg::DIV5_SHIFT +: rfbs_pkg::PIX_W];
      end
      rfbs_pkg::MODE_SHARPEN: begin
        // saturate to 0..255
        if (sharp < 0) begin
          pixel = '0;
        end else if (sharp > $signed(10'(rfbs_pkg::PIX_MAX))) begin
          pixel = rfbs_pkg::PIX_MAX;
        end else begin
          pixel = sharp[7:0];
        end
      end
      default: begin
        pixel = nb[2];
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/row_filter_blur_sharpen_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// row_filter_blur_sharpen_core
// Horizontal row filter with edge replication over a chain of window cells.
// ----------------------------------------------------------------------------
// Latency: the results a pixel causes are shown from the cycle after its
//   transfer, out of a three-slot result register.
// Throughput: one pixel per cycle while out_ready is high; the last pixel of a
//   row may cause up to three results, and the input then waits until the
//   slots drain through the single result port.
// Reset (synchronous, rst_n low): mode pass-through, row width 20, column 0,
//   window cells and result slots empty.
// ----------------------------------------------------------------------------
module row_filter_blur_sharpen_core #(
  parameter int MAX_ROW_WIDTH = rfbs_pkg::MAX_ROW_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // pixel input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rfbs_pkg::PIX_W-1:0]      in_pixel_in,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [rfbs_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                                 out_row_end,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rfbs_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rfbs_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rfbs_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  // Width of a column index / row width that can hold MAX_ROW_WIDTH itself
  localparam int WW   = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH + 1) : 1;
  // Common width for comparing the raw register against the limit
  localparam int CMPW = (WW > rfbs_pkg::WIDTH_REG_W) ? WW : rfbs_pkg::WIDTH_REG_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rfbs_pkg::MODE_W-1:0]      cfg_mode_r;
  logic [rfbs_pkg::WIDTH_REG_W-1:0] cfg_width_r;
  logic                             cfg_write;
  logic                             cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r  <= rfbs_pkg::MODE_PASS;
      cfg_width_r <= rfbs_pkg::ROW_WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rfbs_pkg::REG_FILTER_MODE: cfg_mode_r  <= pwdata[rfbs_pkg::MODE_W-1:0];
        rfbs_pkg::REG_ROW_WIDTH:   cfg_width_r <= pwdata[rfbs_pkg::WIDTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      rfbs_pkg::REG_FILTER_MODE: prdata = rfbs_pkg::APB_DATA_W'(cfg_mode_r);
      rfbs_pkg::REG_ROW_WIDTH:   prdata = rfbs_pkg::APB_DATA_W'(cfg_width_r);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Row control: mode and width are sampled on the row's first pixel
  // --------------------------------------------------------------------------
  logic [rfbs_pkg::MODE_W-1:0] row_mode_r;
  logic [WW-1:0]               row_w_r;
  logic [WW-1:0]               col_r;
  logic [CMPW-1:0]             width_raw;
  logic [WW-1:0]               width_clamped;
  logic [rfbs_pkg::MODE_W-1:0] mode_eff;
  logic [WW-1:0]               width_eff;
  logic                        row_start;
  logic                        row_last;
  logic                        in_xfer;
  logic [1:0]                  lag;

  always_comb begin
    width_raw = CMPW'(cfg_width_r);
    // width zero acts as one, anything past the limit acts as the limit
    if (width_raw == '0) begin
      width_clamped = WW'(1);
    end else if (width_raw > CMPW'(MAX_ROW_WIDTH)) begin
      width_clamped = WW'(MAX_ROW_WIDTH);
    end else begin
      width_clamped = width_raw[WW-1:0];
    end

    row_start = (col_r == '0);
    mode_eff  = row_start ? cfg_mode_r    : row_mode_r;
    width_eff = row_start ? width_clamped : row_w_r;
    row_last  = ((col_r + WW'(1)) >= width_eff);

    case (mode_eff)
      rfbs_pkg::MODE_PASS:  lag = 2'd0;
      rfbs_pkg::MODE_BLUR5: lag = 2'd2;
      default:              lag = 2'd1;
    endcase
  end

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_mode_r <= rfbs_pkg::MODE_PASS;
      row_w_r    <= WW'(rfbs_pkg::ROW_WIDTH_RESET);
      col_r      <= '0;
    end else if (in_xfer) begin
      row_mode_r <= mode_eff;
      row_w_r    <= width_eff;
      col_r      <= row_last ? '0 : col_r + WW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Window: a chain of cells, each one pixel further back in the row.
  // link[0] is the incoming pixel; link[d] holds column (current - d) with
  // the left edge replicated once the row runs out.
  // --------------------------------------------------------------------------
  rfbs_pkg::tap_link_t link [rfbs_pkg::TAP_COUNT];

  assign link[0] = '{pixel: in_pixel_in, valid: 1'b1, clamped: in_pixel_in};

  for (genvar d = 0; d < rfbs_pkg::CELL_COUNT; d++) begin : g_cell
    rfbs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (in_xfer),
      .row_done (row_last),
      .up       (link[d]),
      .down     (link[d+1])
    );
  end

  // --------------------------------------------------------------------------
  // Three filter units, one per output offset m (column current - m).
  // Columns to the right of the current pixel replicate the current pixel.
  // --------------------------------------------------------------------------
  logic [rfbs_pkg::PIX_W-1:0] nb   [rfbs_pkg::SLOT_COUNT][rfbs_pkg::TAP_COUNT];
  logic [rfbs_pkg::PIX_W-1:0] fval [rfbs_pkg::SLOT_COUNT];

  for (genvar m = 0; m < rfbs_pkg::SLOT_COUNT; m++) begin : g_filt
    for (genvar i = 0; i < rfbs_pkg::TAP_COUNT; i++) begin : g_nb
      localparam int D = (m - i + 2 < 0) ? 0 : m - i + 2;
      assign nb[m][i] = link[D].clamped;
    end

    rfbs_filter u_filter (
      .mode  (mode_eff),
      .nb    (nb[m]),
      .pixel (fval[m])
    );
  end

  // --------------------------------------------------------------------------
  // Select which offsets this pixel emits and pack them in column order.
  // Offset m is owed once the row holds column m; the steady output is at
  // offset lag, and the row's last pixel flushes every smaller offset.
  // --------------------------------------------------------------------------
  logic [rfbs_pkg::SLOT_COUNT-1:0] take;
  logic [rfbs_pkg::SLOT_COUNT-1:0] have_col;
  rfbs_pkg::result_t               fill [rfbs_pkg::SLOT_COUNT];
  logic [1:0]                      fill_cnt;

  always_comb begin
    have_col[0] = 1'b1;
    have_col[1] = link[1].valid;
    have_col[2] = link[2].valid;
    for (int m = 0; m < rfbs_pkg::SLOT_COUNT; m++) begin
      take[m] = have_col[m] &&
                ((2'(m) == lag) || (row_last && (2'(m) < lag)));
    end

    fill_cnt = '0;
    for (int s = 0; s < rfbs_pkg::SLOT_COUNT; s++) begin
      fill[s] = '0;
    end
    // walk from the oldest column to the newest
    for (int m = rfbs_pkg::SLOT_COUNT - 1; m >= 0; m--) begin
      if (take[m]) begin
        fill[fill_cnt].pixel   = fval[m];
        fill[fill_cnt].row_end = row_last && (m == 0);
        fill_cnt               = fill_cnt + 2'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result slots: slot 0 faces the output. Take a new pixel once the slots
  // are empty or the last held result transfers in this cycle.
  // --------------------------------------------------------------------------
  rfbs_pkg::result_t slot_r [rfbs_pkg::SLOT_COUNT];
  logic [1:0]        slot_cnt_r;
  logic              out_xfer;

  assign out_valid     = (slot_cnt_r != 2'd0);
  assign out_xfer      = out_valid && out_ready;
  assign in_ready      = (slot_cnt_r == 2'd0) || ((slot_cnt_r == 2'd1) && out_ready);
  assign out_pixel_out = slot_r[0].pixel;
  assign out_row_end   = slot_r[0].row_end;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int s = 0; s < rfbs_pkg::SLOT_COUNT; s++) begin
        slot_r[s] <= fill[s];
      end
    end else if (out_xfer) begin
      // advance the remaining results toward the output
      for (int s = 0; s < rfbs_pkg::SLOT_COUNT - 1; s++) begin
        slot_r[s] <= slot_r[s+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
    end else if (in_xfer) begin
      slot_cnt_r <= fill_cnt;
    end else if (out_xfer) begin
      slot_cnt_r <= slot_cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rfbs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfbs_checker
// Port-level checks of the row filter, bound to the top level.
// ----------------------------------------------------------------------------
module rfbs_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rfbs_pkg::PIX_W-1:0] out_pixel_out,
  input wire logic                       out_row_end
);

  // a held result keeps its payload until it transfers
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pixel_out) && $stable(out_row_end))
    else $error("result changed before transfer");

  // input stalls only while results are waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a blocked result blocks the input
  a_blocked_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is blocked");

  // reset empties the result slots
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind row_filter_blur_sharpen_core rfbs_checker u_rfbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pixel_out (out_pixel_out),
  .out_row_end   (out_row_end)
);
`default_nettype wire
